FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

FILE: rtl/csd_pkg.sv
// Package for the charge session detector: register map, event codes, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package csd_pkg;
  localparam int AddrW = 5;
  localparam logic [AddrW-1:0] RegStartPower   = 5'd0;
  localparam logic [AddrW-1:0] RegStartCurrent = 5'd4;
  localparam logic [AddrW-1:0] RegStartConfirm = 5'd8;
  localparam logic [AddrW-1:0] RegStopPower    = 5'd12;
  localparam logic [AddrW-1:0] RegStopCurrent  = 5'd16;
  localparam logic [AddrW-1:0] RegStopConfirm  = 5'd20;

  localparam logic [1:0] EvIdle     = 2'd0;
  localparam logic [1:0] EvStarted  = 2'd1;
  localparam logic [1:0] EvCharging = 2'd2;
  localparam logic [1:0] EvDone     = 2'd3;

  localparam logic [7:0]  RunMax     = 8'd255;
  localparam logic [11:0] VoltSent   = 12'd4095;
  localparam logic [9:0]  FreqSent   = 10'd1023;
  localparam logic [6:0]  PfFull     = 7'd100;
  localparam logic [17:0] AvgPowMax  = 18'd262143;
  localparam logic [15:0] SecPerHr10 = 16'd36000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV_P, ST_DIV_PF, ST_OUT
  } state_t;
endpackage
`default_nettype wire

FILE: rtl/charge_session_detector.sv
// Charge session detector top level: APB registers, session state, shared
// restoring divider for average power and average PF. Uses csd_pkg, assert_macros.svh.
// Each accepted sample passes ST_MUL, ST_DIV_P (power divide) and ST_DIV_PF (PF divide)
// before out_valid; no new sample is taken until the result has been taken.
// A result stays in the output register until taken; in_stall drops the cycle after.
// Reset (rst, synchronous) restores config, session and state registers to defaults and closes any session.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module charge_session_detector (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [csd_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [11:0] voltage,
  input  wire logic [16:0] current,
  input  wire logic [17:0] active_power,
  input  wire logic [6:0]  pf_sample,
  input  wire logic [9:0]  frequency,
  input  wire logic [23:0] energy_total,
  input  wire logic [31:0] timestamp_s,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       session_event,
  output logic [31:0]      elapsed_s,
  output logic [23:0]      energy_used,
  output logic [17:0]      average_power,
  output logic [6:0]       average_pf,
  output logic [17:0]      peak_power,
  output logic [16:0]      peak_current,
  output logic [11:0]      lowest_voltage,
  output logic [11:0]      highest_voltage,
  output logic [6:0]       lowest_pf,
  output logic [9:0]       lowest_frequency,
  output logic [9:0]       highest_frequency
);
  logic [17:0] start_power_min, stop_power_max;
  logic [16:0] start_current_min, stop_current_max;
  logic [7:0]  start_confirm_count, stop_confirm_count;

  logic session_open;
  logic [7:0] start_run, stop_run;
  logic [31:0] start_time, sample_count;
  logic [23:0] start_energy;
  logic [39:0] pf_sum;
  logic [17:0] max_power_seen;
  logic [16:0] max_current_seen;
  logic [11:0] min_voltage_seen, max_voltage_seen;
  logic [6:0]  min_pf_seen;
  logic [9:0]  min_freq_seen, max_freq_seen;

  csd_pkg::state_t state, state_next;
  logic [5:0] step;
  // shared divider
  logic [39:0] quo;
  logic [40:0] rem;
  logic [31:0] dvs;
  logic [39:0] prod;
  logic [40:0] rem_sh;
  logic [41:0] trial;

  wire cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr)
      csd_pkg::RegStartPower:   prdata = {14'd0, start_power_min};
      csd_pkg::RegStartCurrent: prdata = {15'd0, start_current_min};
      csd_pkg::RegStartConfirm: prdata = {24'd0, start_confirm_count};
      csd_pkg::RegStopPower:    prdata = {14'd0, stop_power_max};
      csd_pkg::RegStopCurrent:  prdata = {15'd0, stop_current_max};
      csd_pkg::RegStopConfirm:  prdata = {24'd0, stop_confirm_count};
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_power_min <= 18'd10000;
      start_current_min <= 17'd3000;
      start_confirm_count <= 8'd3;
      stop_power_max <= 18'd1000;
      stop_current_max <= 17'd500;
      stop_confirm_count <= 8'd5;
    end else if (cfg_wr) begin
      case (paddr)
        csd_pkg::RegStartPower:   start_power_min <= pwdata[17:0];
        csd_pkg::RegStartCurrent: start_current_min <= pwdata[16:0];
        csd_pkg::RegStartConfirm: start_confirm_count <= pwdata[7:0];
        csd_pkg::RegStopPower:    stop_power_max <= pwdata[17:0];
        csd_pkg::RegStopCurrent:  stop_current_max <= pwdata[16:0];
        csd_pkg::RegStopConfirm:  stop_confirm_count <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state != csd_pkg::ST_IDLE);
  wire in_acc = in_valid && !in_stall;

  // session update, done combinationally at acceptance
  logic charging, stopped, opens, closes;
  logic [7:0] srun_n, prun_n;
  always_comb begin
    charging = active_power >= start_power_min && current >= start_current_min;
    stopped  = active_power <= stop_power_max && current <= stop_current_max;
    srun_n = charging ? ((start_run == csd_pkg::RunMax) ? start_run : start_run + 8'd1) : 8'd0;
    prun_n = stopped ? ((stop_run == csd_pkg::RunMax) ? stop_run : stop_run + 8'd1) : 8'd0;
    opens  = !session_open && (srun_n >= start_confirm_count);
    closes = session_open && (prun_n >= stop_confirm_count);
  end

  logic        has_fig;
  logic [23:0] used_r;
  logic [31:0] dur_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      session_open <= 1'b0;
      start_run <= 8'd0;
      stop_run <= 8'd0;
      start_time <= 32'd0;
      start_energy <= 24'd0;
      sample_count <= 32'd0;
      pf_sum <= 40'd0;
      max_power_seen <= 18'd0;
      max_current_seen <= 17'd0;
      min_voltage_seen <= csd_pkg::VoltSent;
      max_voltage_seen <= 12'd0;
      min_pf_seen <= csd_pkg::PfFull;
      min_freq_seen <= csd_pkg::FreqSent;
      max_freq_seen <= 10'd0;
    end else if (in_acc) begin
      if (!session_open) begin
        start_run <= opens ? 8'd0 : srun_n;
        if (opens) begin
          session_open <= 1'b1;
          start_time <= timestamp_s;
          start_energy <= energy_total;
          stop_run <= 8'd0;
          sample_count <= 32'd0;
          pf_sum <= 40'd0;
          max_power_seen <= 18'd0;
          max_current_seen <= 17'd0;
          min_voltage_seen <= csd_pkg::VoltSent;
          max_voltage_seen <= 12'd0;
          min_pf_seen <= csd_pkg::PfFull;
          min_freq_seen <= csd_pkg::FreqSent;
          max_freq_seen <= 10'd0;
        end
      end else begin
        sample_count <= sample_count + 32'd1;
        pf_sum <= pf_sum + {33'd0, pf_sample};
        if (active_power > max_power_seen) max_power_seen <= active_power;
        if (current > max_current_seen) max_current_seen <= current;
        if (voltage < min_voltage_seen) min_voltage_seen <= voltage;
        if (voltage > max_voltage_seen) max_voltage_seen <= voltage;
        if (pf_sample < min_pf_seen) min_pf_seen <= pf_sample;
        if (frequency < min_freq_seen) min_freq_seen <= frequency;
        if (frequency > max_freq_seen) max_freq_seen <= frequency;
        stop_run <= closes ? 8'd0 : prun_n;
        if (closes) session_open <= 1'b0;
      end
    end
  end

  // capture of sample and post-update figures (registered at accept)
  logic [11:0] v_r;
  logic [9:0]  f_r;
  logic [31:0] ts_r;
  logic [23:0] e_r;
  logic [1:0]  ev_r;
  always_ff @(posedge clk) begin
    if (in_acc) begin
      v_r <= voltage;
      f_r <= frequency;
      ts_r <= timestamp_s;
      e_r <= energy_total;
      ev_r <= opens ? csd_pkg::EvStarted : (closes ? csd_pkg::EvDone :
              (session_open ? csd_pkg::EvCharging : csd_pkg::EvIdle));
    end
  end

  always_comb begin
    has_fig = (ev_r != csd_pkg::EvIdle);
    dur_r  = (ts_r >= start_time) ? ts_r - start_time : 32'd0;
    used_r = (e_r >= start_energy) ? e_r - start_energy : 24'd0;
  end

  always_comb begin
    state_next = state;
    case (state)
      csd_pkg::ST_IDLE:   if (in_acc) state_next = csd_pkg::ST_MUL;
      csd_pkg::ST_MUL:    state_next = csd_pkg::ST_DIV_P;
      csd_pkg::ST_DIV_P:  if (step == 6'd40) state_next = csd_pkg::ST_DIV_PF;
      csd_pkg::ST_DIV_PF: if (step == 6'd40) state_next = csd_pkg::ST_OUT;
      csd_pkg::ST_OUT:    if (!out_stall) state_next = csd_pkg::ST_IDLE;
      default:            state_next = csd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= csd_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    rem_sh = {rem[39:0], quo[39]};
    trial = {1'b0, rem_sh} - {10'd0, dvs};
  end

  always_ff @(posedge clk) begin
    case (state)
      csd_pkg::ST_MUL: begin
        prod <= {16'd0, used_r} * {24'd0, csd_pkg::SecPerHr10};
        step <= 6'd0;
      end
      csd_pkg::ST_DIV_P, csd_pkg::ST_DIV_PF: begin
        if (step == 6'd0) begin
          quo <= (state == csd_pkg::ST_DIV_P) ? prod : pf_sum;
          dvs <= (state == csd_pkg::ST_DIV_P) ? dur_r : sample_count;
          rem <= 41'd0;
          step <= 6'd1;
        end else begin
          if (!trial[41]) begin
            rem <= trial[40:0];
            quo <= {quo[38:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[38:0], 1'b0};
          end
          step <= (step == 6'd40) ? 6'd0 : step + 6'd1;
        end
        if (state == csd_pkg::ST_DIV_P && step == 6'd40) begin
          average_power <= (!has_fig || dur_r == 32'd0) ? 18'd0 :
            ((trial[41] ? {quo[38:0], 1'b0} : {quo[38:0], 1'b1}) > {22'd0, csd_pkg::AvgPowMax})
              ? csd_pkg::AvgPowMax
              : (trial[41] ? {quo[16:0], 1'b0} : {quo[16:0], 1'b1});
        end
        if (state == csd_pkg::ST_DIV_PF && step == 6'd40) begin
          average_pf <= (!has_fig || sample_count == 32'd0) ? 7'd0 :
            ((trial[41] ? {quo[38:0], 1'b0} : {quo[38:0], 1'b1}) > {33'd0, csd_pkg::PfFull})
              ? csd_pkg::PfFull
              : (trial[41] ? {quo[5:0], 1'b0} : {quo[5:0], 1'b1});
          session_event <= ev_r;
          elapsed_s <= has_fig ? dur_r : 32'd0;
          energy_used <= has_fig ? used_r : 24'd0;
          peak_power <= has_fig ? max_power_seen : 18'd0;
          peak_current <= has_fig ? max_current_seen : 17'd0;
          lowest_voltage <= !has_fig ? 12'd0 : (v_r < min_voltage_seen ? v_r : min_voltage_seen);
          highest_voltage <= !has_fig ? 12'd0 : (v_r > max_voltage_seen ? v_r : max_voltage_seen);
          lowest_pf <= has_fig ? min_pf_seen : 7'd0;
          lowest_frequency <= !has_fig ? 10'd0 : (f_r < min_freq_seen ? f_r : min_freq_seen);
          highest_frequency <= !has_fig ? 10'd0 : (f_r > max_freq_seen ? f_r : max_freq_seen);
        end
      end
      default: ;
    endcase
  end

  assign out_valid = (state == csd_pkg::ST_OUT);

  `ASSERT_NEVER(a_no_accept_busy, clk, rst, in_acc && out_valid)
  `ASSERT_IMPL(a_out_holds, clk, rst, out_valid && out_stall |=> out_valid && $stable(session_event))
  `ASSERT_IMPL(a_accept_mul, clk, rst, in_acc |=> state == csd_pkg::ST_MUL)
  `ASSERT_NEVER(a_run_closed, clk, rst, !session_open && stop_run != 8'd0)
endmodule
`default_nettype wire
